FILE: design/assert_macros.svh
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CQH_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define CQH_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define CQH_ASSERT(label, clk, rst_n, prop)
`define CQH_NEVER(label, clk, rst_n, cond)
`endif
`endif

FILE: design/cqh_pkg.sv
`timescale 1ns / 1ps
package cqh_pkg;
    localparam int SampleW      = 32;
    localparam int CodeW        = 8;
    localparam int CountW       = 25;
    localparam int KindW        = 2;
    localparam int BinW         = 8;
    localparam int Bins         = 256;
    localparam int CfgIdxW      = 2;
    localparam int NumW         = 40;
    localparam int Steps        = 253;
    localparam int DefMaxPoints = 16777216;
    localparam logic signed [SampleW-1:0] LowerReset = 32'sd16810770;
    localparam logic signed [SampleW-1:0] UpperReset = 32'sd18454938;
    localparam logic [CodeW-1:0] CodeLow  = 8'd0;
    localparam logic [CodeW-1:0] CodeHigh = 8'd255;
    localparam logic [CodeW-1:0] CodeFlat = 8'd1;

    localparam logic [CfgIdxW-1:0] CFG_LOWER = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_UPPER = 2'd1;

    typedef enum logic [KindW-1:0] {
        KIND_QUANT = 2'd0,
        KIND_READ  = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind                     kind;
        logic signed [SampleW-1:0] sample;
        logic [BinW-1:0]           bin_index;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_head;

    typedef struct packed {
        logic pop;
        logic init_done;
    } t_back_stat;

    typedef enum logic [3:0] {
        S_IDLE, S_EVAL, S_MUL, S_DIV, S_HIST_RD, S_HIST_WR,
        S_BIN_RD, S_BIN_DONE, S_CLEAR, S_OUT
    } t_state;
endpackage

FILE: design/cqh_if.sv
`timescale 1ns / 1ps
interface cqh_in_if;
    logic                                valid;
    logic                                ready;
    logic [cqh_pkg::KindW-1:0]           kind;
    logic signed [cqh_pkg::SampleW-1:0]  sample;
    logic [cqh_pkg::BinW-1:0]            bin_index;
    modport source (output valid, kind, sample, bin_index, input ready);
    modport sink (input valid, kind, sample, bin_index, output ready);
endinterface

interface cqh_out_if;
    logic                        valid;
    logic                        ready;
    logic [cqh_pkg::CodeW-1:0]   code;
    logic [cqh_pkg::CountW-1:0]  bin_count;
    modport source (output valid, code, bin_count, input ready);
    modport sink (input valid, code, bin_count, output ready);
endinterface

FILE: design/cqh_ram.sv
`timescale 1ns / 1ps
module cqh_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: design/cqh_front.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cqh_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    cqh_in_if.sink              i_in,
    input  cqh_pkg::t_back_stat i_stat,
    output cqh_pkg::t_head      o_head
);
    cqh_pkg::t_item r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_count;
    logic           w_push;

    assign i_in.ready = (r_count != 2'd2) && i_stat.init_done;
    assign w_push     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= '{kind: cqh_pkg::t_kind'(i_in.kind), sample: i_in.sample,
                             bin_index: i_in.bin_index};
        end
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_stat.pop) r_rp <= ~r_rp;
            r_count <= r_count + 2'(w_push) - 2'(i_stat.pop);
        end
    end

    assign o_head.valid = (r_count != 2'd0);
    assign o_head.item  = r_mem[r_rp];

    `CQH_NEVER(a_pop_empty, i_clk, i_rst_n, i_stat.pop && (r_count == 2'd0))
    `CQH_NEVER(a_over_full, i_clk, i_rst_n, r_count == 2'd3)
    `CQH_ASSERT(a_no_early_push, i_clk, i_rst_n, !i_stat.init_done |-> !w_push)
endmodule

FILE: design/cqh_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cqh_back #(
    parameter int MaxPoints = cqh_pkg::DefMaxPoints
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic signed [cqh_pkg::SampleW-1:0] i_lower,
    input  logic signed [cqh_pkg::SampleW-1:0] i_upper,
    input  cqh_pkg::t_head                     i_head,
    output cqh_pkg::t_back_stat                o_stat,
    cqh_out_if.source                          o_out
);
    localparam int CountMax = (1 << cqh_pkg::CountW) - 1;
    localparam logic [cqh_pkg::CountW-1:0] BinLimit =
        (MaxPoints < CountMax) ? cqh_pkg::CountW'(MaxPoints) : cqh_pkg::CountW'(CountMax);

    cqh_pkg::t_state r_state, n_state;
    cqh_pkg::t_kind  r_kind;
    logic signed [cqh_pkg::SampleW-1:0] r_sample;
    logic [cqh_pkg::BinW-1:0]    r_bin;
    logic [cqh_pkg::SampleW-1:0] r_diff, r_den;
    logic [cqh_pkg::NumW-1:0]    r_rem, r_dsh;
    logic [cqh_pkg::CodeW-1:0]   r_q, r_code;
    logic [2:0]                  r_cnt;
    logic [cqh_pkg::CountW-1:0]  r_count;
    logic [cqh_pkg::BinW-1:0]    r_clr_addr;
    logic                        r_clr_reply, r_init_done;

    logic signed [cqh_pkg::SampleW:0] w_diff, w_den;
    logic w_lt, w_gt, w_ge;
    logic [cqh_pkg::CodeW-1:0]  w_qnext;
    logic                       w_we;
    logic [cqh_pkg::BinW-1:0]   w_waddr, w_raddr;
    logic [cqh_pkg::CountW-1:0] w_wdata, w_rdata;

    assign w_diff  = {r_sample[cqh_pkg::SampleW-1], r_sample} - {i_lower[cqh_pkg::SampleW-1], i_lower};
    assign w_den   = {i_upper[cqh_pkg::SampleW-1], i_upper} - {i_lower[cqh_pkg::SampleW-1], i_lower};
    assign w_lt    = r_sample < i_lower;
    assign w_gt    = r_sample > i_upper;
    assign w_ge    = r_rem >= r_dsh;
    assign w_qnext = {r_q[cqh_pkg::CodeW-2:0], w_ge};

    always_comb begin
        n_state          = r_state;
        o_stat.pop       = 1'b0;
        o_stat.init_done = r_init_done;
        w_we             = 1'b0;
        w_waddr          = r_code;
        w_wdata          = '0;
        w_raddr          = r_code;
        unique case (r_state)
            cqh_pkg::S_IDLE: begin
                if (i_head.valid) begin
                    o_stat.pop = 1'b1;
                    unique case (i_head.item.kind)
                        cqh_pkg::KIND_QUANT: n_state = cqh_pkg::S_EVAL;
                        cqh_pkg::KIND_READ:  n_state = cqh_pkg::S_BIN_RD;
                        cqh_pkg::KIND_CLEAR: n_state = cqh_pkg::S_CLEAR;
                        cqh_pkg::KIND_NONE:  n_state = cqh_pkg::S_OUT;
                        default:             n_state = cqh_pkg::S_OUT;
                    endcase
                end
            end
            cqh_pkg::S_EVAL: begin
                if (w_lt || w_gt || (w_den == '0)) n_state = cqh_pkg::S_HIST_RD;
                else n_state = cqh_pkg::S_MUL;
            end
            cqh_pkg::S_MUL: n_state = cqh_pkg::S_DIV;
            cqh_pkg::S_DIV: begin
                if (r_cnt == 3'd0) n_state = cqh_pkg::S_HIST_RD;
            end
            cqh_pkg::S_HIST_RD: n_state = cqh_pkg::S_HIST_WR;
            cqh_pkg::S_HIST_WR: begin
                w_we    = 1'b1;
                w_wdata = (w_rdata < BinLimit) ? w_rdata + 1'b1 : w_rdata;
                n_state = cqh_pkg::S_OUT;
            end
            cqh_pkg::S_BIN_RD: begin
                w_raddr = r_bin;
                n_state = cqh_pkg::S_BIN_DONE;
            end
            cqh_pkg::S_BIN_DONE: n_state = cqh_pkg::S_OUT;
            cqh_pkg::S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr_addr;
                if (r_clr_addr == '1) n_state = r_clr_reply ? cqh_pkg::S_OUT : cqh_pkg::S_IDLE;
            end
            cqh_pkg::S_OUT: begin
                if (o_out.ready) n_state = cqh_pkg::S_IDLE;
            end
            default: n_state = cqh_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cqh_pkg::S_CLEAR;
            r_clr_addr  <= '0;
            r_clr_reply <= 1'b0;
            r_init_done <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == cqh_pkg::S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == '1) r_init_done <= 1'b1;
            end
            if (r_state == cqh_pkg::S_IDLE && i_head.valid) begin
                r_clr_reply <= 1'b1;
                r_clr_addr  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            cqh_pkg::S_IDLE: begin
                r_kind   <= i_head.item.kind;
                r_sample <= i_head.item.sample;
                r_bin    <= i_head.item.bin_index;
                r_code   <= '0;
                r_count  <= '0;
            end
            cqh_pkg::S_EVAL: begin
                r_diff <= w_diff[cqh_pkg::SampleW-1:0];
                r_den  <= w_den[cqh_pkg::SampleW-1:0];
                if (w_lt) r_code <= cqh_pkg::CodeLow;
                else if (w_gt) r_code <= cqh_pkg::CodeHigh;
                else r_code <= cqh_pkg::CodeFlat;
            end
            cqh_pkg::S_MUL: begin
                r_rem <= cqh_pkg::NumW'(r_diff) * cqh_pkg::NumW'(cqh_pkg::Steps);
                r_dsh <= {1'b0, r_den, 7'b0};
                r_cnt <= 3'd7;
                r_q   <= '0;
            end
            cqh_pkg::S_DIV: begin
                if (w_ge) r_rem <= r_rem - r_dsh;
                r_dsh  <= r_dsh >> 1;
                r_q    <= w_qnext;
                r_cnt  <= r_cnt - 1'b1;
                r_code <= w_qnext + 1'b1;
            end
            cqh_pkg::S_BIN_DONE: r_count <= w_rdata;
            default: ;
        endcase
    end

    cqh_ram #(.Width(cqh_pkg::CountW), .Depth(cqh_pkg::Bins)) u_hist (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_out.valid      = (r_state == cqh_pkg::S_OUT);
    assign o_out.code       = r_code;
    assign o_out.bin_count  = r_count;

    `CQH_ASSERT(a_div_fits, i_clk, i_rst_n, (r_state == cqh_pkg::S_DIV) |-> ({1'b0, r_rem} < {r_dsh, 1'b0}))
    `CQH_ASSERT(a_we_states, i_clk, i_rst_n, w_we |-> (r_state == cqh_pkg::S_HIST_WR || r_state == cqh_pkg::S_CLEAR))
    `CQH_ASSERT(a_out_done, i_clk, i_rst_n, (o_out.valid && o_out.ready) |=> (r_state == cqh_pkg::S_IDLE))
    `CQH_ASSERT(a_kind_path, i_clk, i_rst_n, (r_state == cqh_pkg::S_DIV) |-> (r_kind == cqh_pkg::KIND_QUANT))
endmodule

FILE: design/clamp_quantize_histogram.sv
`timescale 1ns / 1ps
// Clamping 8-bit quantiser with a 256-bin histogram. Each input transfer carries one
// command: kind 0 quantises a signed Q8.24 sample against the lower and upper bound
// registers (below lower gives 0, above upper gives 255, otherwise
// floor((s-lo)*253/(hi-lo))+1, or 1 when the bounds are equal) and counts the code in
// its bin, which saturates at min(MaxPoints, 2^25-1); kind 1 returns the count of
// one bin; kind 2 clears every bin; kind 3 does nothing. Each command yields exactly
// one output transfer, with unused fields zero. A two-entry queue decouples the input
// from the execution engine, which handles one command at a time. A quantise runs
// subtract, multiply, eight restoring division steps, then a read-modify-write of
// the histogram memory when the sample lies within the bounds and they differ, and
// skips to the read-modify-write when it is clamped or the bounds are equal. A clear
// sweeps the 256 bins through the single write port; after reset the same sweep runs
// before the first input transfer is taken. The user must write the bound registers
// through the plain write port only while the block is idle, which is not enforced.
module clamp_quantize_histogram #(
    parameter int MaxPoints = cqh_pkg::DefMaxPoints
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [cqh_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [cqh_pkg::SampleW-1:0]  i_cfg_data,
    cqh_in_if.sink                       i_in,
    cqh_out_if.source                    o_out
);
    logic signed [cqh_pkg::SampleW-1:0] r_lower;
    logic signed [cqh_pkg::SampleW-1:0] r_upper;
    cqh_pkg::t_head      w_head;
    cqh_pkg::t_back_stat w_stat;

    // Bound registers; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower <= cqh_pkg::LowerReset;
            r_upper <= cqh_pkg::UpperReset;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == cqh_pkg::CFG_LOWER) r_lower <= i_cfg_data;
            else if (i_cfg_idx == cqh_pkg::CFG_UPPER) r_upper <= i_cfg_data;
        end
    end

    // Front end: takes transfers into the command queue.
    cqh_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_stat  (w_stat),
        .o_head  (w_head)
    );

    // Back end: quantiser, divider and histogram memory.
    cqh_back #(.MaxPoints(MaxPoints)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_lower (r_lower),
        .i_upper (r_upper),
        .i_head  (w_head),
        .o_stat  (w_stat),
        .o_out   (o_out)
    );
endmodule

FILE: tb/clamp_quantize_histogram_tb.sv
`timescale 1ns / 1ps
module clamp_quantize_histogram_tb;
    import cqh_pkg::*;

    localparam int MismatchShow = 10;
    localparam logic [CountW-1:0] BinLimit =
        CountW'((DefMaxPoints < (1 << CountW) - 1) ? DefMaxPoints : (1 << CountW) - 1);

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0] i_cfg_idx = '0;
    logic [SampleW-1:0] i_cfg_data = '0;

    cqh_in_if  in_ch();
    cqh_out_if out_ch();

    clamp_quantize_histogram u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_in      (in_ch.sink),
        .o_out     (out_ch.source)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    typedef struct packed {
        logic [CodeW-1:0]  code;
        logic [CountW-1:0] count;
    } t_quant_result;

    // Predictor state: bounds and the bin counters, mirroring the block.
    logic signed [SampleW-1:0] pred_lower;
    logic signed [SampleW-1:0] pred_upper;
    logic [CountW-1:0] pred_bins [Bins];
    t_quant_result expected_results [$];
    int error_count = 0;
    bit stimulus_done = 1'b0;

    function automatic logic [CodeW-1:0] quantize_sample(logic signed [SampleW-1:0] s);
        logic [63:0] num;
        logic [63:0] den;
        if (s < pred_lower) return CodeLow;
        if (s > pred_upper) return CodeHigh;
        den = 64'($signed(pred_upper) - $signed(pred_lower));
        if (den == 0) return CodeFlat;
        num = 64'($signed(s) - $signed(pred_lower)) * Steps;
        return CodeW'(num / den + 1);
    endfunction

    // Works out the result of one accepted command and updates the bins.
    function automatic t_quant_result predict_command(t_kind k,
            logic signed [SampleW-1:0] s, logic [BinW-1:0] b);
        t_quant_result r;
        r = '0;
        case (k)
            KIND_QUANT: begin
                r.code = quantize_sample(s);
                if (pred_bins[r.code] < BinLimit) pred_bins[r.code]++;
            end
            KIND_READ: r.count = pred_bins[b];
            KIND_CLEAR: foreach (pred_bins[i]) pred_bins[i] = '0;
            default: ;
        endcase
        return r;
    endfunction

    task automatic write_bound(logic [CfgIdxW-1:0] idx, logic [SampleW-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_LOWER) pred_lower = val;
        else if (idx == CFG_UPPER) pred_upper = val;
        @(posedge i_clk);
    endtask

    // Valid stays high after a transfer and drops only when an idle gap follows.
    task automatic send_command(t_kind k, logic [SampleW-1:0] s, logic [BinW-1:0] b,
            bit fixed_gap);
        int gap;
        gap = fixed_gap ? 0 : $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.kind      <= k;
        in_ch.sample    <= s;
        in_ch.bin_index <= b;
        do @(posedge i_clk); while (!in_ch.ready);
        expected_results.push_back(predict_command(k, s, b));
    endtask

    // Drops valid, waits until every expected result has come, then for the clearing sweep.
    task automatic drain_block();
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    // Output side: random back-pressure, then the check against the oldest expectation.
    initial begin
        int stall;
        t_quant_result want;
        out_ch.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            if (expected_results.size() == 0) begin
                error_count++;
                if (error_count <= MismatchShow)
                    $display("unexpected transfer: code %0d count %0d",
                        out_ch.code, out_ch.bin_count);
            end else begin
                want = expected_results.pop_front();
                if (out_ch.code !== want.code || out_ch.bin_count !== want.count) begin
                    error_count++;
                    if (error_count <= MismatchShow)
                        $display("mismatch: code exp %0d got %0d, count exp %0d got %0d",
                            want.code, out_ch.code, want.count, out_ch.bin_count);
                end
            end
        end
    end

    typedef struct {
        t_kind             kind;
        logic [SampleW-1:0] sample;
        logic [BinW-1:0]   bin;
        bit                typed;
        t_quant_result     want;
    } t_directed_row;

    // Directed commands under the reset bounds; rows marked typed carry an obvious result.
    t_directed_row directed_rows [] = '{
        '{KIND_READ,  32'd0,          8'd0,   1'b1, '{8'd0,   25'd0}},
        '{KIND_READ,  32'd0,          8'd255, 1'b1, '{8'd0,   25'd0}},
        '{KIND_QUANT, 32'h8000_0000,  8'd0,   1'b1, '{8'd0,   25'd0}},
        '{KIND_QUANT, 32'h7FFF_FFFF,  8'd0,   1'b1, '{8'd255, 25'd0}},
        '{KIND_QUANT, 32'd16810770,   8'd0,   1'b1, '{8'd1,   25'd0}},
        '{KIND_QUANT, 32'd18454938,   8'd0,   1'b1, '{8'd254, 25'd0}},
        '{KIND_QUANT, 32'd17500000,   8'd0,   1'b0, '{8'd0,   25'd0}},
        '{KIND_QUANT, 32'd16810769,   8'd0,   1'b1, '{8'd0,   25'd0}},
        '{KIND_QUANT, 32'd18454939,   8'd0,   1'b1, '{8'd255, 25'd0}},
        '{KIND_READ,  32'd0,          8'd0,   1'b1, '{8'd0,   25'd2}},
        '{KIND_READ,  32'd0,          8'd255, 1'b1, '{8'd0,   25'd2}},
        '{KIND_READ,  32'd0,          8'd1,   1'b1, '{8'd0,   25'd1}},
        '{KIND_NONE,  32'hFFFF_FFFF,  8'hFF,  1'b1, '{8'd0,   25'd0}},
        '{KIND_CLEAR, 32'd0,          8'd0,   1'b1, '{8'd0,   25'd0}},
        '{KIND_READ,  32'd0,          8'd255, 1'b1, '{8'd0,   25'd0}}
    };

    // Chooses a sample, mostly near or inside the current bounds.
    function automatic logic [SampleW-1:0] pick_sample();
        int unsigned sel;
        logic signed [63:0] span;
        sel = $urandom_range(0, 9);
        span = $signed(pred_upper) - $signed(pred_lower);
        if (sel < 6 && span >= 0)
            return SampleW'($signed(pred_lower) + (64'($urandom) % (span + 1)));
        if (sel == 6) return pred_lower + SampleW'($urandom_range(0, 4)) - 2;
        if (sel == 7) return pred_upper + SampleW'($urandom_range(0, 4)) - 2;
        return $urandom;
    endfunction

    task automatic run_random(int n);
        int unsigned r;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 75) send_command(KIND_QUANT, pick_sample(), BinW'($urandom), 1'b0);
            else if (r < 92) send_command(KIND_READ, $urandom, BinW'($urandom), 1'b0);
            else if (r < 94) send_command(KIND_CLEAR, $urandom, BinW'($urandom), 1'b0);
            else send_command(KIND_NONE, $urandom, BinW'($urandom), 1'b0);
        end
    endtask

    initial begin
        t_quant_result got;
        pred_lower = LowerReset;
        pred_upper = UpperReset;
        foreach (pred_bins[i]) pred_bins[i] = '0;
        in_ch.valid = 1'b0;
        in_ch.kind = KIND_NONE;
        in_ch.sample = '0;
        in_ch.bin_index = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            got = predict_command(directed_rows[i].kind, directed_rows[i].sample,
                directed_rows[i].bin);
            // Typed rows are compared against the predictor too, so a slip shows up.
            if (directed_rows[i].typed && got != directed_rows[i].want) begin
                error_count++;
                $display("directed row %0d disagrees with the predictor", i);
            end
            // Undo the predictor step; send_command performs it on acceptance.
            if (directed_rows[i].kind == KIND_QUANT && pred_bins[got.code] != 0)
                pred_bins[got.code]--;
            if (directed_rows[i].kind == KIND_CLEAR) begin
                pred_bins[1] = 1;
                pred_bins[0] = 2;
                pred_bins[255] = 2;
                pred_bins[254] = 1;
                pred_bins[quantize_sample(32'd17500000)]++;
            end
            send_command(directed_rows[i].kind, directed_rows[i].sample,
                directed_rows[i].bin, 1'b0);
        end
        drain_block();

        // Equal bounds, then inverted, then the full range, then narrow ones at random.
        write_bound(CFG_LOWER, 32'd5000);
        write_bound(CFG_UPPER, 32'd5000);
        send_command(KIND_QUANT, 32'd5000, 8'd0, 1'b1);
        send_command(KIND_QUANT, 32'd4999, 8'd0, 1'b1);
        run_random(150);
        drain_block();
        write_bound(CFG_LOWER, 32'h7FFF_FFFF);
        write_bound(CFG_UPPER, 32'h8000_0000);
        send_command(KIND_QUANT, 32'h7FFF_FFFF, 8'd0, 1'b1);
        run_random(100);
        drain_block();
        write_bound(CFG_LOWER, 32'h8000_0000);
        write_bound(CFG_UPPER, 32'h7FFF_FFFF);
        send_command(KIND_QUANT, 32'h7FFF_FFFF, 8'd0, 1'b1);
        send_command(KIND_QUANT, 32'h8000_0000, 8'd0, 1'b1);
        run_random(400);
        drain_block();
        // A register index beyond the two bounds must be ignored.
        write_bound(CfgIdxW'(3), 32'h1234_5678);
        write_bound(CfgIdxW'(2), 32'h0000_0001);
        run_random(100);
        repeat (4) begin
            drain_block();
            write_bound(CFG_LOWER, $urandom);
            write_bound(CFG_UPPER, pred_lower + SampleW'($urandom_range(1, 3000)));
            if ($signed(pred_upper) < $signed(pred_lower)) write_bound(CFG_UPPER, 32'h7FFF_FFFF);
            run_random(250);
        end
        drain_block();
        stimulus_done = 1'b1;
    end

    initial begin
        wait (stimulus_done);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("clamp_quantize_histogram_tb: done, clean");
        end else begin
            $display("clamp_quantize_histogram_tb: done, errors");
        end
        $finish;
    end

    // Slowest run: ~1800 items, each up to a full clearing sweep plus both sides' stalls.
    initial begin
        #50_000_000;
        $display("clamp_quantize_histogram_tb: done, errors");
        $finish;
    end
endmodule

FILE: files.f
+incdir+design
design/cqh_pkg.sv
design/cqh_if.sv
design/cqh_ram.sv
design/cqh_front.sv
design/cqh_back.sv
design/clamp_quantize_histogram.sv
tb/clamp_quantize_histogram_tb.sv
